// ===== sv/pqs_pkg.sv =====
// pqs_pkg: shared types and constants of the priority quantum scheduler
package pqs_pkg;

   localparam int unsigned OP_W      = 2;
   localparam int unsigned LABEL_W   = 8;
   localparam int unsigned ARRIVAL_W = 16;
   localparam int unsigned BURST_W   = 16;
   localparam int unsigned PRIO_W    = 8;
   localparam int unsigned QUANTUM_W = 16;
   localparam int unsigned CLOCK_W   = 21;

   localparam logic [CLOCK_W-1:0]   TIME_MAX      = '1;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_STEP  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_STEP,
      CMD_CLEAR,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      logic [LABEL_W-1:0]   label;
      logic [ARRIVAL_W-1:0] arrival;
      logic [BURST_W-1:0]   burst;
      logic [PRIO_W-1:0]    prio;
   } entry_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         burst_zero;
      entry_type    entry;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RUN,
      ST_STAT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               slice_valid;
      logic [LABEL_W-1:0] slice_task;
      logic [CLOCK_W-1:0] slice_start;
      logic [CLOCK_W-1:0] slice_end;
      logic               task_finished;
      logic [CLOCK_W-1:0] turnaround;
      logic [CLOCK_W-1:0] waiting;
      logic               all_done;
      logic               table_full;
   } result_type;

endpackage

// ===== sv/preemptive_priority_quantum_scheduler_unit.sv =====
// preemptive_priority_quantum_scheduler_unit: top level of the priority quantum scheduler
//
//   channel   handshake              payload
//   req       push / full            operation, label, arrival, burst, priority
//   rsp       empty / pop            slice, finish statistics, all_done, table_full
//   csr       csr_valid / csr_ready  time_quantum
//
// load, clear and unknown commands complete in the executor's idle state; a schedule command
// scans the table through one read port, then decides and, with a slice, runs, computes the
// statistics and outputs; without a slice it answers from the decide state.
// the two-entry request queue takes transfers while the executor or the result stalls.
// synchronous reset empties both queues, the table count and the time; the quantum
// returns to 10. the table itself needs no clearing pass.
module preemptive_priority_quantum_scheduler_unit #(
   parameter int unsigned MAX_TASKS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [pqs_pkg::OP_W-1:0]            req_operation,
   input  logic [pqs_pkg::LABEL_W-1:0]         req_task_label,
   input  logic [pqs_pkg::ARRIVAL_W-1:0]       req_arrival_time,
   input  logic [pqs_pkg::BURST_W-1:0]         req_burst_length,
   input  logic [pqs_pkg::PRIO_W-1:0]          req_task_priority,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_slice_valid,
   output logic [pqs_pkg::LABEL_W-1:0]         rsp_slice_task,
   output logic [pqs_pkg::CLOCK_W-1:0]         rsp_slice_start,
   output logic [pqs_pkg::CLOCK_W-1:0]         rsp_slice_end,
   output logic                                rsp_task_finished,
   output logic [pqs_pkg::CLOCK_W-1:0]         rsp_turnaround,
   output logic [pqs_pkg::CLOCK_W-1:0]         rsp_waiting,
   output logic                                rsp_all_done,
   output logic                                rsp_table_full,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pqs_pkg::QUANTUM_W-1:0]       csr_time_quantum
);

   logic [pqs_pkg::QUANTUM_W-1:0] time_quantum_ff;
   logic                          cmd_valid;
   logic                          cmd_take;
   pqs_pkg::cmd_type              cmd;
   pqs_pkg::result_type           res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_quantum_ff <= pqs_pkg::QUANTUM_RESET;
      end else if (csr_valid && csr_ready) begin
         time_quantum_ff <= csr_time_quantum;
      end
   end

   pqs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_operation     (req_operation),
      .req_task_label    (req_task_label),
      .req_arrival_time  (req_arrival_time),
      .req_burst_length  (req_burst_length),
      .req_task_priority (req_task_priority),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take)
   );

   pqs_back #(
      .MAX_TASKS (MAX_TASKS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_take     (cmd_take),
      .time_quantum (time_quantum_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .res          (res)
   );

   assign rsp_slice_valid   = res.slice_valid;
   assign rsp_slice_task    = res.slice_task;
   assign rsp_slice_start   = res.slice_start;
   assign rsp_slice_end     = res.slice_end;
   assign rsp_task_finished = res.task_finished;
   assign rsp_turnaround    = res.turnaround;
   assign rsp_waiting       = res.waiting;
   assign rsp_all_done      = res.all_done;
   assign rsp_table_full    = res.table_full;

endmodule

// ===== sv/pqs_front.sv =====
// pqs_front: accepts and classifies request transfers into a two-entry command queue
module pqs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [pqs_pkg::OP_W-1:0]            req_operation,
   input  logic [pqs_pkg::LABEL_W-1:0]         req_task_label,
   input  logic [pqs_pkg::ARRIVAL_W-1:0]       req_arrival_time,
   input  logic [pqs_pkg::BURST_W-1:0]         req_burst_length,
   input  logic [pqs_pkg::PRIO_W-1:0]          req_task_priority,
   output logic                                cmd_valid,
   output pqs_pkg::cmd_type                    cmd,
   input  logic                                cmd_take
);

   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   pqs_pkg::cmd_type slot_ff [2];
   pqs_pkg::cmd_type cmd_new;
   logic             push_ok;
   logic             pop_ok;

   always_comb begin
      cmd_new.entry.label   = req_task_label;
      cmd_new.entry.arrival = req_arrival_time;
      cmd_new.entry.burst   = req_burst_length;
      cmd_new.entry.prio    = req_task_priority;
      cmd_new.burst_zero    = (req_burst_length == '0);
      unique case (pqs_pkg::op_type'(req_operation))
         pqs_pkg::OP_LOAD:  cmd_new.kind = pqs_pkg::CMD_LOAD;
         pqs_pkg::OP_STEP:  cmd_new.kind = pqs_pkg::CMD_STEP;
         pqs_pkg::OP_CLEAR: cmd_new.kind = pqs_pkg::CMD_CLEAR;
         pqs_pkg::OP_NONE:  cmd_new.kind = pqs_pkg::CMD_NONE;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== sv/pqs_back.sv =====
// pqs_back: task table, ready-task scan and slice execution with a result register
module pqs_back #(
   parameter int unsigned MAX_TASKS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  pqs_pkg::cmd_type                cmd,
   output logic                            cmd_take,
   input  logic [pqs_pkg::QUANTUM_W-1:0]   time_quantum,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output pqs_pkg::result_type             res
);

   localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
   localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int unsigned CW    = pqs_pkg::CLOCK_W;
   localparam int unsigned BW    = pqs_pkg::BURST_W;
   localparam int unsigned QW    = pqs_pkg::QUANTUM_W;

   // task table
   pqs_pkg::entry_type mem_entry [MAX_TASKS];
   logic [BW-1:0]      mem_rem   [MAX_TASKS];

   pqs_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    loaded_ff, loaded_in;
   logic [CNT_W-1:0]    done_ff, done_in;
   logic [CW-1:0]       time_ff, time_in;
   logic [CNT_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_slot_ff, pend_slot_in;
   logic                res_valid_ff, res_valid_in;
   pqs_pkg::result_type res_ff, res_in;

   pqs_pkg::entry_type  rd_entry_ff;
   logic [BW-1:0]       rd_rem_ff;

   logic                rdy_found_ff, rdy_found_in;
   logic [IDX_W-1:0]    rdy_slot_ff, rdy_slot_in;
   pqs_pkg::entry_type  rdy_entry_ff, rdy_entry_in;
   logic [BW-1:0]       rdy_rem_ff, rdy_rem_in;
   logic                arr_found_ff, arr_found_in;
   logic [IDX_W-1:0]    arr_slot_ff, arr_slot_in;
   pqs_pkg::entry_type  arr_entry_ff, arr_entry_in;
   logic [BW-1:0]       arr_rem_ff, arr_rem_in;

   logic [IDX_W-1:0]    sel_slot_ff, sel_slot_in;
   pqs_pkg::entry_type  sel_entry_ff, sel_entry_in;
   logic [BW-1:0]       sel_rem_ff, sel_rem_in;
   logic [CW-1:0]       start_ff, start_in;
   logic [CW-1:0]       end_ff, end_in;
   logic                fin_ff, fin_in;
   logic [CW-1:0]       tat_ff, tat_in;

   logic                slot_free;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_idx;
   logic                we_entry;
   logic                we_rem;
   logic [IDX_W-1:0]    wr_idx;
   logic [BW-1:0]       rem_wdata;
   logic                unfinished;
   logic                arrived;
   logic [QW-1:0]       q_eff;
   logic [BW-1:0]       run_len;
   logic [CW:0]         end_sum;
   logic [CW-1:0]       end_sat;

   assign rsp_empty = !res_valid_ff;
   assign res       = res_ff;
   assign slot_free = !res_valid_ff || rsp_pop;
   assign rd_idx    = scan_addr_ff[IDX_W-1:0];

   // slice length and end time, saturating at the top of the time range
   always_comb begin
      q_eff   = (time_quantum == '0) ? QW'(1) : time_quantum;
      run_len = (q_eff < sel_rem_ff) ? q_eff : sel_rem_ff;
      end_sum = {1'b0, time_ff} + (CW + 1)'(run_len);
      end_sat = end_sum[CW] ? pqs_pkg::TIME_MAX : end_sum[CW-1:0];
   end

   assign unfinished = (rd_rem_ff != '0);
   assign arrived    = (CW'(rd_entry_ff.arrival) <= time_ff);

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      done_in      = done_ff;
      time_in      = time_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = 1'b0;
      pend_slot_in = rd_idx;
      res_valid_in = res_valid_ff && !rsp_pop;
      res_in       = res_ff;
      rdy_found_in = rdy_found_ff;
      rdy_slot_in  = rdy_slot_ff;
      rdy_entry_in = rdy_entry_ff;
      rdy_rem_in   = rdy_rem_ff;
      arr_found_in = arr_found_ff;
      arr_slot_in  = arr_slot_ff;
      arr_entry_in = arr_entry_ff;
      arr_rem_in   = arr_rem_ff;
      sel_slot_in  = sel_slot_ff;
      sel_entry_in = sel_entry_ff;
      sel_rem_in   = sel_rem_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      fin_in       = fin_ff;
      tat_in       = tat_ff;
      cmd_take     = 1'b0;
      rd_en        = 1'b0;
      we_entry     = 1'b0;
      we_rem       = 1'b0;
      wr_idx       = loaded_ff[IDX_W-1:0];
      rem_wdata    = cmd.entry.burst;

      unique case (state_ff)
         pqs_pkg::ST_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_take = 1'b1;
               unique case (cmd.kind)
                  pqs_pkg::CMD_LOAD: begin
                     res_in       = '0;
                     res_valid_in = 1'b1;
                     if (loaded_ff == CNT_W'(MAX_TASKS)) begin
                        res_in.table_full = 1'b1;
                        res_in.all_done   = (done_ff == loaded_ff);
                     end else begin
                        we_entry        = 1'b1;
                        we_rem          = 1'b1;
                        loaded_in       = loaded_ff + CNT_W'(1);
                        done_in         = done_ff + CNT_W'(cmd.burst_zero);
                        res_in.all_done = (done_in == loaded_in);
                     end
                  end
                  pqs_pkg::CMD_STEP: begin
                     scan_addr_in = '0;
                     rdy_found_in = 1'b0;
                     arr_found_in = 1'b0;
                     state_in     = pqs_pkg::ST_SCAN;
                  end
                  pqs_pkg::CMD_CLEAR: begin
                     loaded_in       = '0;
                     done_in         = '0;
                     time_in         = '0;
                     res_in          = '0;
                     res_in.all_done = 1'b1;
                     res_valid_in    = 1'b1;
                  end
                  pqs_pkg::CMD_NONE: begin
                     res_in          = '0;
                     res_in.all_done = (done_ff == loaded_ff);
                     res_valid_in    = 1'b1;
                  end
               endcase
            end
         end

         pqs_pkg::ST_SCAN: begin
            if (scan_addr_ff < loaded_ff) begin
               rd_en        = 1'b1;
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end
            pend_in = rd_en;
            if (pend_ff) begin
               // best ready task, strict compare keeps the lowest slot on a tie
               if (unfinished && arrived &&
                   (!rdy_found_ff || rd_entry_ff.prio > rdy_entry_ff.prio)) begin
                  rdy_found_in = 1'b1;
                  rdy_slot_in  = pend_slot_ff;
                  rdy_entry_in = rd_entry_ff;
                  rdy_rem_in   = rd_rem_ff;
               end
               // earliest arrival, best priority among those arriving then
               if (unfinished &&
                   (!arr_found_ff || rd_entry_ff.arrival < arr_entry_ff.arrival ||
                    (rd_entry_ff.arrival == arr_entry_ff.arrival &&
                     rd_entry_ff.prio > arr_entry_ff.prio))) begin
                  arr_found_in = 1'b1;
                  arr_slot_in  = pend_slot_ff;
                  arr_entry_in = rd_entry_ff;
                  arr_rem_in   = rd_rem_ff;
               end
            end
            if (!rd_en && !pend_ff) begin
               state_in = pqs_pkg::ST_DECIDE;
            end
         end

         pqs_pkg::ST_DECIDE: begin
            if (rdy_found_ff) begin
               sel_slot_in  = rdy_slot_ff;
               sel_entry_in = rdy_entry_ff;
               sel_rem_in   = rdy_rem_ff;
               state_in     = pqs_pkg::ST_RUN;
            end else if (arr_found_ff) begin
               // nothing ready: jump to the next arrival
               sel_slot_in  = arr_slot_ff;
               sel_entry_in = arr_entry_ff;
               sel_rem_in   = arr_rem_ff;
               if (CW'(arr_entry_ff.arrival) > time_ff) begin
                  time_in = CW'(arr_entry_ff.arrival);
               end
               state_in = pqs_pkg::ST_RUN;
            end else begin
               res_in          = '0;
               res_in.all_done = (done_ff == loaded_ff);
               res_valid_in    = 1'b1;
               state_in        = pqs_pkg::ST_IDLE;
            end
         end

         pqs_pkg::ST_RUN: begin
            start_in  = time_ff;
            end_in    = end_sat;
            time_in   = end_sat;
            fin_in    = (sel_rem_ff == run_len);
            we_rem    = 1'b1;
            wr_idx    = sel_slot_ff;
            rem_wdata = sel_rem_ff - run_len;
            state_in  = pqs_pkg::ST_STAT;
         end

         pqs_pkg::ST_STAT: begin
            tat_in   = end_ff - CW'(sel_entry_ff.arrival);
            state_in = pqs_pkg::ST_OUT;
         end

         pqs_pkg::ST_OUT: begin
            res_in             = '0;
            res_in.slice_valid = 1'b1;
            res_in.slice_task  = sel_entry_ff.label;
            res_in.slice_start = start_ff;
            res_in.slice_end   = end_ff;
            if (fin_ff) begin
               done_in              = done_ff + CNT_W'(1);
               res_in.task_finished = 1'b1;
               res_in.turnaround    = tat_ff;
               res_in.waiting       = (tat_ff > CW'(sel_entry_ff.burst)) ?
                                      tat_ff - CW'(sel_entry_ff.burst) : '0;
            end
            res_in.all_done = (done_in == loaded_ff);
            res_valid_in    = 1'b1;
            state_in        = pqs_pkg::ST_IDLE;
         end

         default: begin
            state_in = pqs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_entry) begin
         mem_entry[wr_idx] <= cmd.entry;
      end
      if (we_rem) begin
         mem_rem[wr_idx] <= rem_wdata;
      end
      if (rd_en) begin
         rd_entry_ff <= mem_entry[rd_idx];
         rd_rem_ff   <= mem_rem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqs_pkg::ST_IDLE;
         loaded_ff    <= '0;
         done_ff      <= '0;
         time_ff      <= '0;
         scan_addr_ff <= '0;
         pend_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
         rdy_found_ff <= 1'b0;
         arr_found_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         done_ff      <= done_in;
         time_ff      <= time_in;
         scan_addr_ff <= scan_addr_in;
         pend_ff      <= pend_in;
         res_valid_ff <= res_valid_in;
         rdy_found_ff <= rdy_found_in;
         arr_found_ff <= arr_found_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      res_ff       <= res_in;
      rdy_slot_ff  <= rdy_slot_in;
      rdy_entry_ff <= rdy_entry_in;
      rdy_rem_ff   <= rdy_rem_in;
      arr_slot_ff  <= arr_slot_in;
      arr_entry_ff <= arr_entry_in;
      arr_rem_ff   <= arr_rem_in;
      sel_slot_ff  <= sel_slot_in;
      sel_entry_ff <= sel_entry_in;
      sel_rem_ff   <= sel_rem_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      fin_ff       <= fin_in;
      tat_ff       <= tat_in;
   end

endmodule

// ===== sv/pqs_checker.sv =====
// pqs_checker: port-level assertions for the scheduler, bound to the top level
module pqs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic                          rsp_slice_valid,
   input logic [pqs_pkg::LABEL_W-1:0]   rsp_slice_task,
   input logic [pqs_pkg::CLOCK_W-1:0]   rsp_slice_start,
   input logic [pqs_pkg::CLOCK_W-1:0]   rsp_slice_end,
   input logic                          rsp_task_finished,
   input logic [pqs_pkg::CLOCK_W-1:0]   rsp_turnaround,
   input logic [pqs_pkg::CLOCK_W-1:0]   rsp_waiting,
   input logic                          rsp_table_full
);

   // a waiting result holds until it is popped
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_slice_task) &&
                                 $stable(rsp_slice_end) && $stable(rsp_task_finished))
      else $error("result changed while stalled");

   // no slice: slice fields read zero
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_slice_valid |-> rsp_slice_task == '0 && rsp_slice_start == '0 &&
                                         rsp_slice_end == '0 && !rsp_task_finished &&
                                         rsp_turnaround == '0 && rsp_waiting == '0)
      else $error("slice fields set without a slice");

   // a slice moves time forward unless time is saturated
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_slice_valid |-> rsp_slice_end >= rsp_slice_start &&
         (rsp_slice_end != rsp_slice_start || rsp_slice_end == pqs_pkg::TIME_MAX))
      else $error("slice does not advance time");

   // a finish belongs to a slice, and waiting never exceeds turnaround
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_task_finished |-> rsp_slice_valid && !rsp_table_full &&
                                          rsp_waiting <= rsp_turnaround)
      else $error("inconsistent finish statistics");

   assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result present after reset");

endmodule

bind preemptive_priority_quantum_scheduler_unit pqs_checker u_pqs_checker (.*);
